// ===== sv/nmea_gga_vtg_field_extractor_unit_macros.svh =====
`ifndef NMEA_GGA_VTG_FIELD_EXTRACTOR_UNIT_MACROS_SVH
`define NMEA_GGA_VTG_FIELD_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NGE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nge_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nge_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChUpperV = 8'h56;
  localparam logic [7:0] ChUpperT = 8'h54;
  localparam logic [7:0] ChUpperG = 8'h47;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChZero   = 8'h30;

  localparam int unsigned TokQueueDepth = 4;
  localparam int unsigned ResQueueDepth = 2;

  typedef enum logic {
    KIND_FIELD  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    FLD_TIME     = 3'd0,
    FLD_LAT      = 3'd1,
    FLD_LAT_HEMI = 3'd2,
    FLD_LON      = 3'd3,
    FLD_LON_HEMI = 3'd4,
    FLD_ALTITUDE = 3'd5,
    FLD_SPEED    = 3'd6
  } field_e;

  typedef enum logic [1:0] {
    STYPE_OTHER = 2'd0,
    STYPE_GGA   = 2'd1,
    STYPE_VTG   = 2'd2
  } stype_e;

  typedef enum logic [1:0] {
    STAR_NONE = 2'd0,
    STAR_SEEN = 2'd1,
    STAR_ONE  = 2'd2,
    STAR_TWO  = 2'd3
  } star_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_dollar;
    logic       is_term;
    logic       is_star;
    logic       is_comma;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_g;
    logic       is_v;
    logic       is_t;
    logic       is_a;
  } token_t;

  typedef struct packed {
    kind_e      kind;
    field_e     field_code;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    stype_e     sentence_type;
    logic       checksum_ok;
    logic       overflow;
  } result_t;

  typedef struct packed {
    logic   hit;
    field_e code;
  } field_sel_t;

  function automatic field_sel_t field_lookup(stype_e stype, logic [3:0] commas);
    field_sel_t sel;
    sel.hit  = 1'b0;
    sel.code = FLD_TIME;
    if (stype == STYPE_GGA) begin
      sel.hit = 1'b1;
      case (commas)
        4'd1: sel.code = FLD_TIME;
        4'd2: sel.code = FLD_LAT;
        4'd3: sel.code = FLD_LAT_HEMI;
        4'd4: sel.code = FLD_LON;
        4'd5: sel.code = FLD_LON_HEMI;
        4'd9: sel.code = FLD_ALTITUDE;
        default: sel.hit = 1'b0;
      endcase
    end else if (stype == STYPE_VTG && commas == 4'd7) begin
      sel.hit  = 1'b1;
      sel.code = FLD_SPEED;
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nge_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nge_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nge_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nge_front
  import nge_pkg::*;
(
  input  wire logic [7:0] rx_byte_i,
  output token_t          tok_o
);

  always_comb begin
    tok_o           = '0;
    tok_o.data      = rx_byte_i;
    tok_o.is_dollar = (rx_byte_i == ChDollar);
    tok_o.is_term   = (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
    tok_o.is_star   = (rx_byte_i == ChStar);
    tok_o.is_comma  = (rx_byte_i == ChComma);
    tok_o.is_g      = (rx_byte_i == ChUpperG);
    tok_o.is_v      = (rx_byte_i == ChUpperV);
    tok_o.is_t      = (rx_byte_i == ChUpperT);
    tok_o.is_a      = (rx_byte_i == ChUpperA);
    if (rx_byte_i inside {[8'h30:8'h39]}) begin
      tok_o.is_hex  = 1'b1;
      tok_o.hex_val = 4'(rx_byte_i - ChZero);
    end else if (rx_byte_i inside {[8'h41:8'h46]}) begin
      tok_o.is_hex  = 1'b1;
      tok_o.hex_val = 4'(rx_byte_i - ChUpperA + 8'd10);
    end
  end

endmodule

`default_nettype wire

// ===== sv/nge_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_gga_vtg_field_extractor_unit_macros.svh"

module nge_back
  import nge_pkg::*;
#(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   tok_valid_i,
  input  wire token_t tok_i,
  output logic        tok_pop_o,
  input  wire logic   res_full_i,
  output logic        res_push_o,
  output result_t     res_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_LEN);

  logic       in_sent_q, in_sent_d;
  logic [7:0] char_count_q, char_count_d;
  logic [3:0] comma_count_q, comma_count_d;
  logic [7:0] xor_sum_q, xor_sum_d;
  star_e      star_q, star_d;
  logic [7:0] recv_sum_q, recv_sum_d;
  logic       hex_err_q, hex_err_d;
  stype_e     type_match_q, type_match_d;
  stype_e     type_part_q, type_part_d;
  logic [3:0] field_pos_q, field_pos_d;
  logic       overflow_q, overflow_d;
  field_sel_t sel;

  assign tok_pop_o = tok_valid_i && !res_full_i;
  assign sel       = field_lookup(type_match_q, comma_count_q);

  always_comb begin
    in_sent_d     = in_sent_q;
    char_count_d  = char_count_q;
    comma_count_d = comma_count_q;
    xor_sum_d     = xor_sum_q;
    star_d        = star_q;
    recv_sum_d    = recv_sum_q;
    hex_err_d     = hex_err_q;
    type_match_d  = type_match_q;
    type_part_d   = type_part_q;
    field_pos_d   = field_pos_q;
    overflow_d    = overflow_q;
    res_push_o    = 1'b0;
    res_o         = '0;

    if (tok_pop_o) begin
      if (tok_i.is_dollar) begin
        in_sent_d     = 1'b1;
        char_count_d  = '0;
        comma_count_d = '0;
        xor_sum_d     = '0;
        star_d        = STAR_NONE;
        recv_sum_d    = '0;
        hex_err_d     = 1'b0;
        type_match_d  = STYPE_OTHER;
        type_part_d   = STYPE_OTHER;
        field_pos_d   = '0;
        overflow_d    = 1'b0;
      end else if (!in_sent_q) begin
        in_sent_d = 1'b0;
      end else if (tok_i.is_term) begin
        in_sent_d           = 1'b0;
        res_push_o          = 1'b1;
        res_o.kind          = KIND_STATUS;
        res_o.sentence_type = type_match_q;
        res_o.overflow      = overflow_q;
        res_o.checksum_ok   = (star_q == STAR_TWO) && !hex_err_q &&
                              (recv_sum_q == xor_sum_q) && !overflow_q;
      end else if (char_count_q >= MaxLen) begin
        overflow_d = 1'b1;
      end else begin
        char_count_d = char_count_q + 8'd1;

        case (char_count_q)
          8'd2: begin
            type_part_d = tok_i.is_g ? STYPE_GGA : (tok_i.is_v ? STYPE_VTG : STYPE_OTHER);
          end
          8'd3: begin
            if (!((type_part_q == STYPE_GGA && tok_i.is_g) ||
                  (type_part_q == STYPE_VTG && tok_i.is_t))) begin
              type_part_d = STYPE_OTHER;
            end
          end
          8'd4: begin
            if (type_part_q == STYPE_GGA && tok_i.is_a) begin
              type_match_d = STYPE_GGA;
            end else if (type_part_q == STYPE_VTG && tok_i.is_g) begin
              type_match_d = STYPE_VTG;
            end else begin
              type_match_d = STYPE_OTHER;
            end
          end
          default: ;
        endcase

        if (star_q != STAR_NONE) begin
          if (star_q != STAR_TWO) begin
            if (tok_i.is_hex) begin
              recv_sum_d = {recv_sum_q[3:0], tok_i.hex_val};
            end else begin
              hex_err_d = 1'b1;
            end
            star_d = (star_q == STAR_SEEN) ? STAR_ONE : STAR_TWO;
          end
        end else if (tok_i.is_star) begin
          star_d = STAR_SEEN;
        end else begin
          xor_sum_d = xor_sum_q ^ tok_i.data;
          if (char_count_q >= 8'd5) begin
            if (tok_i.is_comma) begin
              if (comma_count_q != 4'd15) begin
                comma_count_d = comma_count_q + 4'd1;
              end
              field_pos_d = '0;
            end else if (sel.hit) begin
              res_push_o       = 1'b1;
              res_o.kind       = KIND_FIELD;
              res_o.field_code = sel.code;
              res_o.char_pos   = field_pos_q;
              res_o.char_value = tok_i.data;
              if (field_pos_q != 4'd15) begin
                field_pos_d = field_pos_q + 4'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q     <= 1'b0;
      char_count_q  <= '0;
      comma_count_q <= '0;
      xor_sum_q     <= '0;
      star_q        <= STAR_NONE;
      recv_sum_q    <= '0;
      hex_err_q     <= 1'b0;
      type_match_q  <= STYPE_OTHER;
      type_part_q   <= STYPE_OTHER;
      field_pos_q   <= '0;
      overflow_q    <= 1'b0;
    end else begin
      in_sent_q     <= in_sent_d;
      char_count_q  <= char_count_d;
      comma_count_q <= comma_count_d;
      xor_sum_q     <= xor_sum_d;
      star_q        <= star_d;
      recv_sum_q    <= recv_sum_d;
      hex_err_q     <= hex_err_d;
      type_match_q  <= type_match_d;
      type_part_q   <= type_part_d;
      field_pos_q   <= field_pos_d;
      overflow_q    <= overflow_d;
    end
  end

  `NGE_ASSERT_IMP(a_ok_not_overflow, res_push_o && res_o.kind == KIND_STATUS && res_o.checksum_ok, !res_o.overflow, "checksum ok reported on an overflowed sentence")
  `NGE_ASSERT_IMP(a_end_has_status, $fell(in_sent_q), $past(res_push_o && res_o.kind == KIND_STATUS), "sentence closed without a status word")
  `NGE_ASSERT_IMP(a_push_from_pop, res_push_o, tok_pop_o, "result word produced without a consumed byte")
  `NGE_ASSERT_NEXT(a_dollar_restart, tok_pop_o && tok_i.is_dollar, in_sent_q && char_count_q == 8'd0, "dollar did not restart the sentence")

endmodule

`default_nettype wire

// ===== sv/nmea_gga_vtg_field_extractor_unit.sv =====
// A byte passes the byte queue and the parser step; its result word is registered in the result queue.
// Throughput: one byte per cycle while the result queue is not full, behind a 4-word byte queue.
// full rises only when the byte queue is filled while the 2-word result queue is held full.
// Reset (asynchronous, active low) empties both queues and puts the parser outside a sentence.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_vtg_field_extractor_unit
  import nge_pkg::*;
#(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            kind_o,
  output logic [2:0]      field_code_o,
  output logic [3:0]      char_pos_o,
  output logic [7:0]      char_value_o,
  output logic [1:0]      sentence_type_o,
  output logic            checksum_ok_o,
  output logic            overflow_o
);

  token_t  tok_in, tok_out;
  result_t res_in, res_out;
  logic    tok_empty, tok_pop;
  logic    res_full, res_push;

  nge_front u_front (
    .rx_byte_i (rx_byte_i),
    .tok_o     (tok_in)
  );

  nge_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (TokQueueDepth)
  ) u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (tok_in),
    .full_o  (full),
    .rd_i    (tok_pop),
    .rdata_o (tok_out),
    .empty_o (tok_empty)
  );

  nge_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!tok_empty),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  nge_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign kind_o          = res_out.kind;
  assign field_code_o    = res_out.field_code;
  assign char_pos_o      = res_out.char_pos;
  assign char_value_o    = res_out.char_value;
  assign sentence_type_o = res_out.sentence_type;
  assign checksum_ok_o   = res_out.checksum_ok;
  assign overflow_o      = res_out.overflow;

endmodule

`default_nettype wire

// ===== test/nmea_gga_vtg_field_extractor_unit_test.sv =====
`timescale 1ns / 1ps

module nmea_gga_vtg_field_extractor_unit_test;
  import nge_pkg::*;

  localparam int MaxLen = 128;

  class sentence_scoreboard;
    result_t    want_q[$];
    int         errors;
    int         max_len;
    bit         in_sent;
    logic [7:0] n_stored;
    logic [3:0] n_commas;
    logic [7:0] xor_acc;
    star_e      star_st;
    logic [7:0] sum_rx;
    bit         sum_bad;
    stype_e     stype;
    stype_e     stype_cand;
    logic [3:0] pos_in_field;
    bit         too_long;

    function new(int len);
      max_len = len;
      errors = 0;
      in_sent = 0;
      restart();
    endfunction

    function void restart();
      n_stored = '0;
      n_commas = '0;
      xor_acc = '0;
      star_st = STAR_NONE;
      sum_rx = '0;
      sum_bad = 0;
      stype = STYPE_OTHER;
      stype_cand = STYPE_OTHER;
      pos_in_field = '0;
      too_long = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    task report(input string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    function void note_byte(input logic [7:0] b);
      logic [7:0] idx;
      result_t    r;
      field_e     code;
      bit         hit;
      r = '0;
      if (b == ChDollar) begin
        restart();
        in_sent = 1;
        return;
      end
      if (!in_sent) return;
      if (b == ChCr || b == ChLf) begin
        r.kind = KIND_STATUS;
        r.sentence_type = stype;
        r.checksum_ok = (star_st == STAR_TWO) && !sum_bad && (sum_rx == xor_acc) && !too_long;
        r.overflow = too_long;
        want_q.push_back(r);
        in_sent = 0;
        return;
      end
      if (n_stored >= max_len) begin
        too_long = 1;
        return;
      end
      idx = n_stored;
      n_stored++;
      case (idx)
        8'd2: stype_cand = (b == ChUpperG) ? STYPE_GGA :
                           (b == ChUpperV) ? STYPE_VTG : STYPE_OTHER;
        8'd3: if (!((stype_cand == STYPE_GGA && b == ChUpperG) ||
                    (stype_cand == STYPE_VTG && b == ChUpperT))) stype_cand = STYPE_OTHER;
        8'd4: stype = (stype_cand == STYPE_GGA && b == ChUpperA) ? STYPE_GGA :
                      (stype_cand == STYPE_VTG && b == ChUpperG) ? STYPE_VTG : STYPE_OTHER;
        default: ;
      endcase
      if (star_st != STAR_NONE) begin
        if (star_st != STAR_TWO) begin
          if (b >= ChZero && b <= ChZero + 8'd9) begin
            sum_rx = {sum_rx[3:0], 4'(b - ChZero)};
          end else if (b >= ChUpperA && b <= ChUpperA + 8'd5) begin
            sum_rx = {sum_rx[3:0], 4'(b - ChUpperA + 8'd10)};
          end else begin
            sum_bad = 1;
          end
          star_st = star_e'(star_st + 2'd1);
        end
        return;
      end
      if (b == ChStar) begin
        star_st = STAR_SEEN;
        return;
      end
      xor_acc ^= b;
      if (idx < 8'd5) return;
      if (b == ChComma) begin
        if (n_commas != 4'd15) n_commas++;
        pos_in_field = '0;
        return;
      end
      hit = 1;
      code = FLD_TIME;
      if (stype == STYPE_GGA) begin
        case (n_commas)
          4'd1: code = FLD_TIME;
          4'd2: code = FLD_LAT;
          4'd3: code = FLD_LAT_HEMI;
          4'd4: code = FLD_LON;
          4'd5: code = FLD_LON_HEMI;
          4'd9: code = FLD_ALTITUDE;
          default: hit = 0;
        endcase
      end else if (stype == STYPE_VTG && n_commas == 4'd7) begin
        code = FLD_SPEED;
      end else begin
        hit = 0;
      end
      if (!hit) return;
      r.kind = KIND_FIELD;
      r.field_code = code;
      r.char_pos = pos_in_field;
      r.char_value = b;
      want_q.push_back(r);
      if (pos_in_field != 4'd15) pos_in_field++;
    endfunction

    task check_word(input result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected word kind=%0d code=%0d value=%h",
                         got.kind, got.field_code, got.char_value));
        return;
      end
      want = want_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.field_code !== want.field_code)
        report($sformatf("field_code %0d, want %0d", got.field_code, want.field_code));
      if (got.char_pos !== want.char_pos)
        report($sformatf("char_pos %0d, want %0d", got.char_pos, want.char_pos));
      if (got.char_value !== want.char_value)
        report($sformatf("char_value %h, want %h", got.char_value, want.char_value));
      if (got.sentence_type !== want.sentence_type)
        report($sformatf("sentence_type %0d, want %0d", got.sentence_type, want.sentence_type));
      if (got.checksum_ok !== want.checksum_ok)
        report($sformatf("checksum_ok %0d, want %0d", got.checksum_ok, want.checksum_ok));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %0d, want %0d", got.overflow, want.overflow));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       hold_pop = 1'b0;
  wire        full;
  wire        empty;
  wire        kind_o;
  wire [2:0]  field_code_o;
  wire [3:0]  char_pos_o;
  wire [7:0]  char_value_o;
  wire [1:0]  sentence_type_o;
  wire        checksum_ok_o;
  wire        overflow_o;

  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  int          sent_count = 0;
  logic [7:0]  line_q[$];
  result_t     seen_w;
  sentence_scoreboard book = new(MaxLen);

  nmea_gga_vtg_field_extractor_unit #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .field_code_o   (field_code_o),
    .char_pos_o     (char_pos_o),
    .char_value_o   (char_value_o),
    .sentence_type_o(sentence_type_o),
    .checksum_ok_o  (checksum_ok_o),
    .overflow_o     (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) book.note_byte(rx_byte_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      seen_w.kind = kind_e'(kind_o);
      seen_w.field_code = field_e'(field_code_o);
      seen_w.char_pos = char_pos_o;
      seen_w.char_value = char_value_o;
      seen_w.sentence_type = stype_e'(sentence_type_o);
      seen_w.checksum_ok = checksum_ok_o;
      seen_w.overflow = overflow_o;
      book.check_word(seen_w);
    end
  end

  always @(posedge clk_i) begin
    if (hold_pop) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic hold_results(input int cycles);
    hold_pop <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_pop <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == ChDollar || c == ChStar || c == ChCr || c == ChLf);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? ChZero + 8'(v) : ChUpperA + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] talker_char();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return ChComma;
    if (r == 1) return plain_byte();
    return ChUpperA + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] field_char();
    string digits;
    digits = "0123456789.NSEWMK";
    if ($urandom_range(19) == 0) return plain_byte();
    return digits[$urandom_range(digits.len() - 1)];
  endfunction

  task automatic build_line();
    int unsigned pick;
    int          nfields;
    logic [7:0]  sum;
    string       letters;
    letters = "GVTAX";
    line_q = {};
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
      return;
    end
    line_q.push_back(ChDollar);
    repeat (2) line_q.push_back(talker_char());
    pick = $urandom_range(9);
    if (pick < 4) begin
      line_q.push_back(ChUpperG);
      line_q.push_back(ChUpperG);
      line_q.push_back(ChUpperA);
      nfields = ($urandom_range(3) == 0) ? $urandom_range(20) : 14;
    end else if (pick < 7) begin
      line_q.push_back(ChUpperV);
      line_q.push_back(ChUpperT);
      line_q.push_back(ChUpperG);
      nfields = ($urandom_range(3) == 0) ? $urandom_range(20) : 8;
    end else begin
      repeat (3) line_q.push_back(letters[$urandom_range(4)]);
      nfields = $urandom_range(10);
    end
    for (int f = 0; f < nfields; f++) begin
      line_q.push_back(ChComma);
      repeat (($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(5))
        line_q.push_back(field_char());
    end
    if ($urandom_range(14) == 0) begin
      repeat ($urandom_range(100, 140)) line_q.push_back(field_char());
    end
    sum = '0;
    for (int i = 1; i < line_q.size(); i++) sum ^= line_q[i];
    pick = $urandom_range(19);
    if (pick != 0) line_q.push_back(ChStar);
    case (pick)
      0, 1: ;
      2: line_q.push_back(hex_char(sum[7:4]));
      3: begin
        sum ^= 8'($urandom_range(1, 255));
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(hex_char(sum[3:0]));
      end
      4: begin
        line_q.push_back((ChUpperA | 8'h20) + 8'($urandom_range(5)));
        line_q.push_back(hex_char(sum[3:0]));
      end
      5: begin
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(plain_byte());
      end
      6: begin
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(hex_char(sum[3:0]));
        repeat ($urandom_range(1, 3)) line_q.push_back(field_char());
      end
      default: begin
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(hex_char(sum[3:0]));
      end
    endcase
    pick = $urandom_range(9);
    if (pick == 1) begin
      line_q.push_back(ChLf);
    end else if (pick == 2) begin
      line_q.push_back(ChCr);
    end else if (pick != 0) begin
      line_q.push_back(ChCr);
      line_q.push_back(ChLf);
    end
  endtask

  task automatic run_phase(input int n_bytes);
    int stop_at;
    stop_at = sent_count + n_bytes;
    while (sent_count < stop_at) begin
      build_line();
      foreach (line_q[i]) send_byte(line_q[i]);
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChLf);
    send_text("$GPGGA,1,A*4");
    send_byte(ChCr);
    send_byte(ChLf);
    send_text("$$,");
    send_byte(ChCr);

    fork
      hold_results(400);
      run_phase(440);
    join
    send_idle = 83;
    run_phase(440);
    send_idle = 0;
    stall_pct = 83;
    run_phase(440);
    send_idle = 37;
    stall_pct = 37;
    run_phase(440);

    push <= 1'b0;
    stall_pct = 0;
    waited = 0;
    while (book.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (book.pending() != 0) book.report($sformatf("%0d words never arrived", book.pending()));
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
